### rtl/afrm_pkg.sv
// afrm_pkg: shared types, constants and the control program of the frame rate meter
// used by afrm_seq, afrm_div and adaptive_frame_rate_meter_unit; depends on nothing
package afrm_pkg;

  // field widths
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned RATE_W  = 25;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned WIN_W   = 8;
  localparam int unsigned BITS_W  = 16;
  localparam int unsigned MAXBR_W = 16;
  localparam int unsigned CFG_W   = 25;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned PROD_W  = RATE_W + BITS_W - 1;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned PC_W    = 4;

  // constants of the rate computation
  localparam logic [NOW_W-1:0]  DT_FAST     = 32'd50;
  localparam logic [NOW_W-1:0]  DT_SLOW     = 32'd80;
  localparam logic [16:0]       RATE_SCALE  = 17'd100000;
  localparam logic [WIN_W-1:0]  WIN_FLOOR   = 8'd2;
  localparam logic [WIN_W-1:0]  TALLY_SAT   = 8'd255;
  localparam logic [STEP_W-1:0] STEP_MIN    = 16'd1;
  localparam logic [STEP_W-1:0] STEP_MAX    = 16'd65535;

  // register reset values
  localparam logic [BITS_W-1:0]  BITS_RST  = 16'd1024;
  localparam logic [MAXBR_W-1:0] MAXBR_RST = 16'd100;
  localparam logic [RATE_W-1:0]  START_RST = 25'd3200;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_BITS_AT_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_BITRATE   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_START_RATE    = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LATCH     = 4'd1;
  localparam logic [3:0] OP_TALLY     = 4'd2;
  localparam logic [3:0] OP_DT        = 4'd3;
  localparam logic [3:0] OP_ADAPT     = 4'd4;
  localparam logic [3:0] OP_DIV_RATE  = 4'd5;
  localparam logic [3:0] OP_RATE_UPD  = 4'd6;
  localparam logic [3:0] OP_PROD      = 4'd7;
  localparam logic [3:0] OP_DIV_STEPS = 4'd8;
  localparam logic [3:0] OP_STEP_UPD  = 4'd9;
  localparam logic [3:0] OP_EMIT      = 4'd10;

  // jump conditions
  localparam logic [2:0] C_NEVER        = 3'd0;
  localparam logic [2:0] C_ALWAYS       = 3'd1;
  localparam logic [2:0] C_NO_INPUT     = 3'd2;
  localparam logic [2:0] C_UNDER_WINDOW = 3'd3;
  localparam logic [2:0] C_DT_ZERO      = 3'd4;
  localparam logic [2:0] C_DIV_BUSY     = 3'd5;
  localparam logic [2:0] C_OUT_BLOCKED  = 3'd6;
  localparam logic [2:0] C_STEP_SPECIAL = 3'd7;

  // program steps
  localparam logic [PC_W-1:0] S_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] S_TALLY      = 4'd1;
  localparam logic [PC_W-1:0] S_DT         = 4'd2;
  localparam logic [PC_W-1:0] S_ADAPT      = 4'd3;
  localparam logic [PC_W-1:0] S_DIV_RATE   = 4'd4;
  localparam logic [PC_W-1:0] S_WAIT_RATE  = 4'd5;
  localparam logic [PC_W-1:0] S_RATE_UPD   = 4'd6;
  localparam logic [PC_W-1:0] S_PROD       = 4'd7;
  localparam logic [PC_W-1:0] S_DIV_STEPS  = 4'd8;
  localparam logic [PC_W-1:0] S_WAIT_STEPS = 4'd9;
  localparam logic [PC_W-1:0] S_STEP_UPD   = 4'd10;
  localparam logic [PC_W-1:0] S_OUT_WAIT   = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT       = 4'd12;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] jmp;
  } ucode_t;

  typedef struct packed {
    logic [3:0] op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic under_window;
    logic dt_zero;
    logic div_busy;
    logic out_blocked;
    logic step_special;
  } stat_t;

  // control store: when the condition holds the step jumps, otherwise it falls through
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    case (pc)
      S_IDLE:       uw = '{op: OP_LATCH,     cond: C_NO_INPUT,     jmp: S_IDLE};
      S_TALLY:      uw = '{op: OP_TALLY,     cond: C_NEVER,        jmp: S_IDLE};
      S_DT:         uw = '{op: OP_DT,        cond: C_UNDER_WINDOW, jmp: S_PROD};
      S_ADAPT:      uw = '{op: OP_ADAPT,     cond: C_DT_ZERO,      jmp: S_PROD};
      S_DIV_RATE:   uw = '{op: OP_DIV_RATE,  cond: C_NEVER,        jmp: S_IDLE};
      S_WAIT_RATE:  uw = '{op: OP_NOP,       cond: C_DIV_BUSY,     jmp: S_WAIT_RATE};
      S_RATE_UPD:   uw = '{op: OP_RATE_UPD,  cond: C_NEVER,        jmp: S_IDLE};
      S_PROD:       uw = '{op: OP_PROD,      cond: C_NEVER,        jmp: S_IDLE};
      S_DIV_STEPS:  uw = '{op: OP_DIV_STEPS, cond: C_STEP_SPECIAL, jmp: S_OUT_WAIT};
      S_WAIT_STEPS: uw = '{op: OP_NOP,       cond: C_DIV_BUSY,     jmp: S_WAIT_STEPS};
      S_STEP_UPD:   uw = '{op: OP_STEP_UPD,  cond: C_NEVER,        jmp: S_IDLE};
      S_OUT_WAIT:   uw = '{op: OP_NOP,       cond: C_OUT_BLOCKED,  jmp: S_OUT_WAIT};
      S_EMIT:       uw = '{op: OP_EMIT,      cond: C_ALWAYS,       jmp: S_IDLE};
      default:      uw = '{op: OP_NOP,       cond: C_ALWAYS,       jmp: S_IDLE};
    endcase
    return uw;
  endfunction

endpackage

### rtl/adaptive_frame_rate_meter_unit.sv
// adaptive_frame_rate_meter_unit: top level, datapath of the frame rate meter
// depends on afrm_pkg, afrm_seq and afrm_div
//
// usage: each transfer on the in_ channel is one frame event, in_tdata the
// millisecond timestamp. every frame gives exactly one transfer on the out_
// channel carrying the smoothed rate (hundredths of fps), the steps per bit
// and the current window size; out_tuser is high when this frame closed a
// window and updated the rate.
// a control program steps a small datapath, and one serial divider runs first for
// the new rate when a window closes with a nonzero interval and then for the
// steps per bit; the next transfer can follow in the cycle after the result is
// loaded. the steps division is skipped when the limit is not positive, the
// product is zero or the bitrate is zero.
// in_tready is high only while the program waits at its idle step.
// the result sits in an output register; a stalled receiver holds the program
// before its next result, and input is taken again once that result is loaded.
// cfg_ writes are registered; the user must make them only while the block is idle, which the block does not enforce.
// reset (synchronous, active low) restores the register defaults, clears the
// frame count, sets a window of one frame and loads the default start rate.
module adaptive_frame_rate_meter_unit #(
  parameter int unsigned MAX_SAMPLES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [24:0] rate_x100, [40:25] step_count, [48:41] window_size
  output logic        out_tuser,  // [0] window_done
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  import afrm_pkg::*;

  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_SAMPLES);

  ctrl_t ctrl;
  stat_t stat;

  // configuration
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [MAXBR_W-1:0] maxbr_r, maxbr_nxt;

  // meter state
  logic [WIN_W-1:0]  tally_r, tally_nxt;
  logic [WIN_W-1:0]  target_r, target_nxt;
  logic [NOW_W-1:0]  start_r, start_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic              done_r, done_nxt;

  // working registers
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [NOW_W-1:0]  dt_r, dt_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_done_r, out_done_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;
  logic [STEP_W-1:0] out_steps_r, out_steps_nxt;
  logic [WIN_W-1:0]  out_win_r, out_win_nxt;

  // divider
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_busy;
  logic [DIV_W-1:0]  div_quo;

  logic              step_special;
  logic [STEP_W-1:0] step_special_val;
  logic [RATE_W+8:0] rate_sum;

  afrm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  afrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_tready = rst_n && (ctrl.op == OP_LATCH);

  always_comb begin
    // non-positive limit or zero product give one step; zero bitrate saturates
    step_special     = bits_r[BITS_W-1] || (bits_r == '0) || (acc_r == '0) ||
                       (maxbr_r == '0);
    step_special_val = (bits_r[BITS_W-1] || (bits_r == '0) || (acc_r == '0)) ?
                       STEP_MIN : STEP_MAX;

    stat.in_valid     = in_tvalid;
    stat.under_window = (tally_r < target_r);
    stat.dt_zero      = (dt_r == '0);
    stat.div_busy     = div_busy;
    stat.out_blocked  = out_valid_r && !out_tready;
    stat.step_special = step_special;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {24'b0, tally_r} * {15'b0, RATE_SCALE};
    div_divisor  = dt_r;
    if (ctrl.op == OP_DIV_RATE) begin
      div_start = 1'b1;
    end else if (ctrl.op == OP_DIV_STEPS) begin
      div_start    = !step_special;
      div_dividend = acc_r[PROD_W-1:8];
      div_divisor  = {16'b0, maxbr_r};
    end
  end

  always_comb begin
    bits_nxt      = bits_r;
    maxbr_nxt     = maxbr_r;
    tally_nxt     = tally_r;
    target_nxt    = target_r;
    start_nxt     = start_r;
    rate_nxt      = rate_r;
    done_nxt      = done_r;
    now_nxt       = now_r;
    dt_nxt        = dt_r;
    acc_nxt       = acc_r;
    steps_nxt     = steps_r;
    out_done_nxt  = out_done_r;
    out_rate_nxt  = out_rate_r;
    out_steps_nxt = out_steps_r;
    out_win_nxt   = out_win_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    rate_sum      = {9'b0, rate_r} + {2'b0, div_quo};

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BITS_AT_LIMIT: bits_nxt  = cfg_data[BITS_W-1:0];
        CFG_MAX_BITRATE:   maxbr_nxt = cfg_data[MAXBR_W-1:0];
        // start rate is read only by reset, which also restores its default
        CFG_START_RATE:    ;
        default:           ;
      endcase
    end

    case (ctrl.op)
      OP_LATCH: begin
        if (in_tvalid) begin
          now_nxt  = in_tdata;
          done_nxt = 1'b0;
        end
      end
      OP_TALLY: begin
        if (tally_r != TALLY_SAT) begin
          tally_nxt = tally_r + 1'b1;
        end
      end
      OP_DT: dt_nxt = now_r - start_r;
      OP_ADAPT: begin
        if (dt_r < DT_FAST) begin
          if (target_r < WIN_MAX) begin
            target_nxt = target_r + 1'b1;
          end
        end else if (dt_r > DT_SLOW) begin
          target_nxt = (target_r > WIN_FLOOR) ? target_r - 1'b1 : WIN_FLOOR;
        end
      end
      OP_RATE_UPD: begin
        rate_nxt  = rate_sum[RATE_W:1];
        start_nxt = now_r;
        tally_nxt = '0;
        done_nxt  = 1'b1;
      end
      OP_PROD: acc_nxt = {15'b0, rate_r} * {25'b0, bits_r[BITS_W-2:0]};
      OP_DIV_STEPS: begin
        if (step_special) begin
          steps_nxt = step_special_val;
        end
      end
      OP_STEP_UPD: begin
        if (div_quo == '0) begin
          steps_nxt = STEP_MIN;
        end else if (div_quo[DIV_W-1:STEP_W] != '0) begin
          steps_nxt = STEP_MAX;
        end else begin
          steps_nxt = div_quo[STEP_W-1:0];
        end
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_done_nxt  = done_r;
        out_rate_nxt  = rate_r;
        out_steps_nxt = steps_r;
        out_win_nxt   = target_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= BITS_RST;
      maxbr_r     <= MAXBR_RST;
      tally_r     <= '0;
      target_r    <= WIN_W'(1);
      start_r     <= '0;
      rate_r      <= START_RST;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bits_r      <= bits_nxt;
      maxbr_r     <= maxbr_nxt;
      tally_r     <= tally_nxt;
      target_r    <= target_nxt;
      start_r     <= start_nxt;
      rate_r      <= rate_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    dt_r        <= dt_nxt;
    acc_r       <= acc_nxt;
    steps_r     <= steps_nxt;
    out_done_r  <= out_done_nxt;
    out_rate_r  <= out_rate_nxt;
    out_steps_r <= out_steps_nxt;
    out_win_r   <= out_win_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_done_r;
  assign out_tdata  = {7'b0, out_win_r, out_steps_r, out_rate_r};

  assert property (@(posedge clk) disable iff (!rst_n) target_r != '0)
    else $error("window size reached zero");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> tally_r == '0)
    else $error("window closed but frame count not cleared");
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !div_busy)
    else $error("input taken while divider still running");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> out_steps_r != '0)
    else $error("result with zero steps per bit");
  assert property (@(posedge clk) disable iff (!rst_n)
                   ctrl.op == OP_EMIT |-> !out_valid_r)
    else $error("result loaded over one not yet taken");

endmodule

### rtl/afrm_div.sv
// afrm_div: restoring serial divider, one quotient bit per cycle
// depends on afrm_pkg for the operand width
module afrm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [afrm_pkg::DIV_W-1:0] dividend,
  input  logic [afrm_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [afrm_pkg::DIV_W-1:0] quotient
);
  import afrm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             fits;

  always_comb begin
    shifted  = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    fits     = !diff[DIV_W+1];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIV_W:0] : shifted;
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with no bits left");
  assert property (@(posedge clk) disable iff (!rst_n)
                   busy_r && cnt_r == CNT_W'(1) |=> !busy_r)
    else $error("divider did not finish after its last bit");

endmodule

### rtl/afrm_seq.sv
// afrm_seq: step counter and control store of the frame rate meter
// depends on afrm_pkg for the program, the control word and the status flags
module afrm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  afrm_pkg::stat_t stat,
  output afrm_pkg::ctrl_t ctrl
);
  import afrm_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uw;
  logic            take;

  always_comb begin
    uw = ucode_rom(pc_r);
    case (uw.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_INPUT:     take = !stat.in_valid;
      C_UNDER_WINDOW: take = stat.under_window;
      C_DT_ZERO:      take = stat.dt_zero;
      C_DIV_BUSY:     take = stat.div_busy;
      C_OUT_BLOCKED:  take = stat.out_blocked;
      C_STEP_SPECIAL: take = stat.step_special;
      default:        take = 1'b0;
    endcase
    pc_nxt  = take ? uw.jmp : pc_r + 1'b1;
    ctrl.op = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pc_r <= S_EMIT)
    else $error("step counter left the program");
  assert property (@(posedge clk) disable iff (!rst_n)
                   pc_r == S_EMIT |=> pc_r == S_IDLE)
    else $error("program did not return to idle after a result");
  assert property (@(posedge clk) disable iff (!rst_n)
                   pc_r == S_WAIT_RATE && !stat.div_busy |=> pc_r == S_RATE_UPD)
    else $error("rate wait did not fall through when divider finished");

endmodule
